// ----- sv/eulerian_circuit_finder_assert.svh -----
// Assertion macros shared by the Eulerian circuit finder RTL.
`ifndef EULERIAN_CIRCUIT_FINDER_ASSERT_SVH
`define EULERIAN_CIRCUIT_FINDER_ASSERT_SVH

// Implication checked every clock edge outside reset.
`define ECF_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ECF_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

// ----- sv/ecf_pkg.sv -----
// ----------------------------------------------------------------------------
// ecf_pkg
// Shared types and constants for the Eulerian circuit finder.
// ----------------------------------------------------------------------------
package ecf_pkg;
   localparam int MaxVerticesDefault = 16;
   localparam int MaxDegreeDefault   = 16;
   localparam int MaxEdgesDefault    = 32;

   localparam int VertexWidth = 4;
   localparam int DegreeWidth = 5;
   localparam int CountWidth  = 5;

   typedef enum logic [1:0] {
      KIND_CIRCUIT  = 2'd0,
      KIND_ODD      = 2'd1,
      KIND_NO_CIRC  = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

   typedef struct packed {
      logic [VertexWidth-1:0] end_a;
      logic [VertexWidth-1:0] end_b;
      logic                   has_edge;
      logic                   last_item;
   } req_type;

   typedef struct packed {
      kind_type               kind;
      logic [VertexWidth-1:0] vertex;
      logic [DegreeWidth-1:0] degree;
      logic                   last_result;
   } rsp_type;
endpackage

// ----- sv/ecf_stream_if.sv -----
// ----------------------------------------------------------------------------
// ecf_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ecf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/ecf_ram.sv -----
// ----------------------------------------------------------------------------
// ecf_ram
// Single-write, single-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ecf_ram #(
   parameter int Width = 4,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/eulerian_circuit_finder.sv -----
// ----------------------------------------------------------------------------
// eulerian_circuit_finder
// Loads undirected multigraph edges and reports an Eulerian circuit
// (Hierholzer's walk from vertex 0), the odd-degree vertices, or overflow.
// ----------------------------------------------------------------------------
// Channel  | Direction | Payload                                  | Handshake
// req      | in        | end_a, end_b, has_edge, last_item        | valid/ready
// rsp      | out       | kind, vertex, degree, last_result        | valid/ready
// csr      | in        | vertex_count at byte address 0           | APB, pready=1
//
// An edge is accepted in IDLE, which adds end_b to end_a's neighbor list, and
// finishes in EDGE_B, which adds end_a to end_b's list, each with its degree
// update; a new edge is taken only once EDGE_B is done. A final transaction
// passes CHECK for overflow and SCAN over the vertices, then walks: a push
// reads the stack top (TOP, TOP_W), takes a neighbor (STEP, NB_W) and erases
// the reverse entry by comparing (ER_RD, ER_CMP) and shifting (SHIFT) list
// entries; a pop reads the top and adds it to the circuit. Results drain
// from the walk memory in DRAIN and DRAIN_W. Every result waits in one output
// register; the block stalls while it is full and not taken. Reset is
// synchronous and clears control state and degree counts; no clearing pass.
// ----------------------------------------------------------------------------
`include "eulerian_circuit_finder_assert.svh"

module eulerian_circuit_finder
   import ecf_pkg::*;
#(
   parameter int MAX_EDGES    = MaxEdgesDefault
) (
   input  logic        clock,
   input  logic        reset,
   ecf_stream_if.sink  req,
   ecf_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   // The vertex and degree limits are tied to the field widths of the
   // transactions, so they follow the package.
   localparam int MAX_VERTICES = MaxVerticesDefault;
   localparam int MAX_DEGREE   = MaxDegreeDefault;

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int SD = MAX_EDGES + 1;
   localparam int SW = $clog2(SD + 1);
   localparam int SAW = $clog2(SD);
   localparam int NAW = $clog2(MAX_VERTICES * MAX_DEGREE);
   localparam int LW = $clog2(MAX_DEGREE);
   localparam int EW = $clog2(MAX_EDGES + 1);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int WD = 2 * SD;
   localparam int WAW = $clog2(WD);

   typedef enum logic [14:0] {
      ST_IDLE    = 15'b000000000000001,
      ST_EDGE_B  = 15'b000000000000010,
      ST_CHECK   = 15'b000000000000100,
      ST_SCAN    = 15'b000000000001000,
      ST_ODD_OUT = 15'b000000000010000,
      ST_FAIL    = 15'b000000000100000,
      ST_TOP     = 15'b000000001000000,
      ST_TOP_W   = 15'b000000010000000,
      ST_STEP    = 15'b000000100000000,
      ST_NB_W    = 15'b000001000000000,
      ST_ER_RD   = 15'b000010000000000,
      ST_ER_CMP  = 15'b000100000000000,
      ST_SHIFT   = 15'b001000000000000,
      ST_DRAIN   = 15'b010000000000000,
      ST_DRAIN_W = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]    vcount_ff, vcount_in;
   logic [DW-1:0] deg_ff [MAX_VERTICES];
   logic [EW-1:0] edges_ff, edges_in;
   logic          ovf_ff, ovf_in;
   logic [SW-1:0] depth_ff, depth_in;
   logic [SW-1:0] clen_ff, clen_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          odd_ff, odd_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in;
   logic          fin_ff, fin_in;
   logic [VW-1:0] u_ff, u_in, v_ff, v_in;
   logic [LW:0]   idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          shift_phase_ff, shift_phase_in;

   // Neighbor memory signals.
   logic           nb_we;
   logic [NAW-1:0] nb_wa, nb_ra;
   logic [VW-1:0]  nb_wd, nb_rd;
   // Stack and circuit views of the walk memory.
   logic           st_we, cb_we;
   logic [SAW-1:0] st_wa, st_ra, cb_wa, cb_ra;
   logic [VW-1:0]  st_wd, st_rd, cb_wd, cb_rd;
   // Walk memory: the stack sits in the lower half, the circuit in the upper.
   logic           wk_we;
   logic [WAW-1:0] wk_wa, wk_ra;
   logic [VW-1:0]  wk_wd, wk_rd;

   ecf_ram #(.Width(VW), .Depth(MAX_VERTICES * MAX_DEGREE)) u_nb (
      .clock, .wr_en(nb_we), .wr_addr(nb_wa), .wr_data(nb_wd),
      .rd_addr(nb_ra), .rd_data(nb_rd));
   ecf_ram #(.Width(VW), .Depth(WD)) u_walk (
      .clock, .wr_en(wk_we), .wr_addr(wk_wa), .wr_data(wk_wd),
      .rd_addr(wk_ra), .rd_data(wk_rd));

   // The stack is written while pushing and the circuit while popping, and the
   // circuit is read only while draining, so the two never collide.
   assign wk_we = st_we || cb_we;
   assign wk_wa = cb_we ? WAW'(SD) + WAW'(cb_wa) : WAW'(st_wa);
   assign wk_wd = cb_we ? cb_wd : st_wd;
   assign wk_ra = (state_ff inside {ST_DRAIN, ST_DRAIN_W}) ?
                  WAW'(SD) + WAW'(cb_ra) : WAW'(st_ra);
   assign st_rd = wk_rd;
   assign cb_rd = wk_rd;

   function automatic logic [NAW-1:0] nb_addr(input logic [VW-1:0] v,
                                              input logic [DW-1:0] i);
      logic [NAW+DW-1:0] full;
      begin
         full = NAW'(v) * NAW'(MAX_DEGREE) + (NAW+DW)'(i);
         return full[NAW-1:0];
      end
   endfunction

   // Effective vertex count, clipped to the array size.
   logic [CW-1:0] eff_n;
   always_comb begin
      if (32'(vcount_ff) > 32'(MAX_VERTICES)) begin
         eff_n = CW'(MAX_VERTICES);
      end else begin
         eff_n = CW'(vcount_ff);
      end
   end

   // Configuration port.
   logic csr_write;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == {REG_VERTEX_COUNT, 1'b0});
   assign csr_prdata = (csr_paddr == {REG_VERTEX_COUNT, 1'b0}) ?
                       {27'd0, vcount_ff} : 32'd0;

   // Edge admission logic evaluated on the incoming transaction.
   logic          in_range, self_loop, cap_fail;
   logic [VW-1:0] ra, rb;
   logic [DW:0]   da_ext, db_ext;
   always_comb begin
      ra = req.data.end_a[VW-1:0];
      rb = req.data.end_b[VW-1:0];
      in_range = (CW'(req.data.end_a) < eff_n) && (CW'(req.data.end_b) < eff_n);
      self_loop = (ra == rb);
      da_ext = {1'b0, deg_ff[ra]};
      db_ext = {1'b0, deg_ff[rb]};
      if (32'(edges_ff) >= 32'(MAX_EDGES)) begin
         cap_fail = 1'b1;
      end else if (self_loop) begin
         cap_fail = (32'(da_ext) + 32'd2) > 32'(MAX_DEGREE);
      end else begin
         cap_fail = (32'(da_ext) >= 32'(MAX_DEGREE)) ||
                    (32'(db_ext) >= 32'(MAX_DEGREE));
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   // Degree update requests.
   logic          deg_clear, deg_inc_a, deg_inc_b, deg_dec_u, deg_dec_v;

   always_comb begin
      state_in = state_ff;
      vcount_in = csr_write ? csr_pwdata[4:0] : vcount_ff;
      edges_in = edges_ff;
      ovf_in = ovf_ff;
      depth_in = depth_ff;
      clen_in = clen_ff;
      scan_in = scan_ff;
      odd_in = odd_ff;
      a_in = a_ff;
      b_in = b_ff;
      fin_in = fin_ff;
      u_in = u_ff;
      v_in = v_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in = rsp_data_ff;
      nb_we = 1'b0;
      nb_wa = nb_addr(a_ff, deg_ff[a_ff]);
      nb_wd = b_ff;
      nb_ra = nb_addr(v_ff, DW'(idx_ff));
      st_we = 1'b0;
      st_wa = depth_ff[SAW-1:0];
      st_wd = v_ff;
      st_ra = SAW'(depth_ff - SW'(1));
      cb_we = 1'b0;
      cb_wa = clen_ff[SAW-1:0];
      cb_wd = u_ff;
      cb_ra = SAW'(clen_ff - SW'(1));
      deg_clear = 1'b0;
      deg_inc_a = 1'b0;
      deg_inc_b = 1'b0;
      deg_dec_u = 1'b0;
      deg_dec_v = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               a_in = ra;
               b_in = rb;
               fin_in = req.data.last_item;
               if (req.data.has_edge && in_range && !ovf_ff && cap_fail) begin
                  ovf_in = 1'b1;
                  state_in = req.data.last_item ? ST_CHECK : ST_IDLE;
               end else if (req.data.has_edge && in_range && !ovf_ff) begin
                  // First half: append b to a's list.
                  nb_we = 1'b1;
                  nb_wa = nb_addr(ra, deg_ff[ra]);
                  nb_wd = rb;
                  deg_inc_a = 1'b1;
                  edges_in = edges_ff + EW'(1);
                  state_in = ST_EDGE_B;
               end else begin
                  state_in = req.data.last_item ? ST_CHECK : ST_IDLE;
               end
            end
         end
         ST_EDGE_B: begin
            nb_we = 1'b1;
            nb_wa = nb_addr(b_ff, deg_ff[b_ff]);
            nb_wd = a_ff;
            deg_inc_b = 1'b1;
            state_in = fin_ff ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            scan_in = '0;
            odd_in = 1'b0;
            if (ovf_ff) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = '{KIND_OVERFLOW, '0, '0, 1'b1};
                  deg_clear = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff >= eff_n) begin
               state_in = odd_ff ? ST_FAIL : ST_TOP;
               depth_in = SW'(1);
               clen_in = '0;
               v_in = '0;
               // Seed the stack with vertex 0.
               st_we = 1'b1;
               st_wa = '0;
               st_wd = '0;
            end else if (deg_ff[scan_ff[VW-1:0]][0]) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.kind = KIND_ODD;
                  rsp_data_in.vertex = VertexWidth'(scan_ff);
                  rsp_data_in.degree = DegreeWidth'(deg_ff[scan_ff[VW-1:0]]);
                  rsp_data_in.last_result = 1'b0;
                  odd_in = 1'b1;
                  scan_in = scan_ff + CW'(1);
               end
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_ODD_OUT: begin
            state_in = ST_FAIL;
         end
         ST_FAIL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '{KIND_NO_CIRC, '0, '0, 1'b1};
               deg_clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_TOP: begin
            // Stack top read issued; data valid next cycle.
            if (depth_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_TOP_W;
            end
         end
         ST_TOP_W: begin
            u_in = st_rd;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (deg_ff[u_ff] != '0 && 32'(depth_ff) < SD) begin
               deg_dec_u = 1'b1;
               nb_ra = nb_addr(u_ff, deg_ff[u_ff] - DW'(1));
               state_in = ST_NB_W;
            end else begin
               if (32'(clen_ff) < SD) begin
                  cb_we = 1'b1;
                  clen_in = clen_ff + SW'(1);
               end
               depth_in = depth_ff - SW'(1);
               state_in = ST_TOP;
            end
         end
         ST_NB_W: begin
            v_in = nb_rd;
            st_we = 1'b1;
            st_wd = nb_rd;
            depth_in = depth_ff + SW'(1);
            idx_in = '0;
            state_in = ST_ER_RD;
         end
         ST_ER_RD: begin
            // Read entry idx of v's list.
            if (32'(idx_ff) >= 32'(deg_ff[v_ff])) begin
               state_in = ST_TOP;
            end else begin
               nb_ra = nb_addr(v_ff, DW'(idx_ff));
               state_in = ST_ER_CMP;
            end
         end
         ST_ER_CMP: begin
            if (nb_rd == u_ff) begin
               state_in = ST_SHIFT;
            end else begin
               idx_in = idx_ff + (LW+1)'(1);
               state_in = ST_ER_RD;
            end
         end
         ST_SHIFT: begin
            // Move entry idx+1 down to idx: the read phase fetches it and the write
            // phase stores it.
            if (32'(idx_ff) + 1 >= 32'(deg_ff[v_ff])) begin
               deg_dec_v = 1'b1;
               state_in = ST_TOP;
            end else if (shift_phase_ff) begin
               nb_we = 1'b1;
               nb_wa = nb_addr(v_ff, DW'(idx_ff));
               nb_wd = nb_rd;
               idx_in = idx_ff + (LW+1)'(1);
            end else begin
               nb_ra = nb_addr(v_ff, DW'(idx_ff) + DW'(1));
            end
         end
         ST_DRAIN: begin
            // Circuit read for entry clen-1 is issued here.
            state_in = ST_DRAIN_W;
         end
         ST_DRAIN_W: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.kind = KIND_CIRCUIT;
               rsp_data_in.vertex = VertexWidth'(cb_rd);
               rsp_data_in.degree = '0;
               rsp_data_in.last_result = (clen_ff == SW'(1));
               clen_in = clen_ff - SW'(1);
               if (clen_ff == SW'(1)) begin
                  deg_clear = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DRAIN;
                  cb_ra = SAW'(clen_ff - SW'(2));
               end
            end else begin
               cb_ra = SAW'(clen_ff - SW'(1));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (deg_clear) begin
         edges_in = '0;
         ovf_in = 1'b0;
         depth_in = '0;
      end
   end

   // Shift phase toggles: read cycle then write cycle.
   always_comb begin
      shift_phase_in = (state_ff == ST_SHIFT) &&
                       (32'(idx_ff) + 1 < 32'(deg_ff[v_ff])) && !shift_phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vcount_ff <= 5'd16;
         edges_ff <= '0;
         ovf_ff <= 1'b0;
         depth_ff <= '0;
         clen_ff <= '0;
         rsp_valid_ff <= 1'b0;
         shift_phase_ff <= 1'b0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            deg_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         vcount_ff <= vcount_in;
         edges_ff <= edges_in;
         ovf_ff <= ovf_in;
         depth_ff <= depth_in;
         clen_ff <= clen_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_phase_ff <= shift_phase_in;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            if (deg_clear) begin
               deg_ff[i] <= '0;
            end else begin
               if ((deg_inc_a && a_in == VW'(i) && state_ff == ST_IDLE) ||
                   (deg_inc_b && b_ff == VW'(i))) begin
                  deg_ff[i] <= deg_ff[i] + DW'(1);
               end else if ((deg_dec_u && u_ff == VW'(i)) ||
                            (deg_dec_v && v_ff == VW'(i))) begin
                  deg_ff[i] <= deg_ff[i] - DW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      odd_ff <= odd_in;
      a_ff <= a_in;
      b_ff <= b_in;
      fin_ff <= fin_in;
      u_ff <= u_in;
      v_ff <= v_in;
      idx_ff <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ECF_ASSERT_IMPLY(a_busy_no_ready, clock, reset,
      state_ff != ST_IDLE, !req.ready, "ready raised while busy")
   `ECF_ASSERT_IMPLY(a_depth_bound, clock, reset,
      1'b1, 32'(depth_ff) <= SD, "walk stack exceeded its depth")
   `ECF_ASSERT_NEXT(a_last_to_idle, clock, reset,
      rsp_valid_in && rsp_data_in.last_result && !rsp_valid_ff,
      state_ff == ST_IDLE, "final result not followed by idle")
endmodule
